/* src/mrte_pkg.sv */
// Shared types, constants and action codes for the R-type execute block.
package mrte_pkg;

    localparam int REG_COUNT  = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_WIDTH  = 5;
    localparam logic [IDX_WIDTH-1:0]  LINK_REG = 5'd31;
    localparam logic [DATA_WIDTH-1:0] PC_STEP  = 32'd4;

    typedef enum logic [4:0] {
        ACT_ADD   = 5'd0,
        ACT_ADDU  = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_SUBU  = 5'd3,
        ACT_MULT  = 5'd4,
        ACT_MULTU = 5'd5,
        ACT_DIV   = 5'd6,
        ACT_DIVU  = 5'd7,
        ACT_AND   = 5'd8,
        ACT_NOR   = 5'd9,
        ACT_OR    = 5'd10,
        ACT_XOR   = 5'd11,
        ACT_SLL   = 5'd12,
        ACT_SLLV  = 5'd13,
        ACT_SRL   = 5'd14,
        ACT_SRA   = 5'd15,
        ACT_SRLV  = 5'd16,
        ACT_SRAV  = 5'd17,
        ACT_SLT   = 5'd18,
        ACT_SLTU  = 5'd19,
        ACT_JR    = 5'd20,
        ACT_JALR  = 5'd21,
        ACT_MFHI  = 5'd22,
        ACT_MFLO  = 5'd23,
        ACT_LOAD  = 5'd24
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_DIVFIX,
        ST_CLEAR,
        ST_OUT
    } state_t;

endpackage

/* src/mips_r_type_execute.sv */
// Top level of the R-type execute block: register file, HI/LO and the sequencer.
// An item passes through the read and output states for most actions and for a divide by
// zero; mult and multu add a multiply state, and div and divu with a nonzero divisor add
// the one-bit-per-cycle restoring divider and a sign-fix state before output.
// The result word sits in an output register; the next word is accepted after it leaves.
// After reset the register file is cleared by a pass over all 32 entries, one entry per cycle,
// during which no word is accepted; HI and LO reset to zero.
module mips_r_type_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  action,
    input  logic [4:0]  src_a_index,
    input  logic [4:0]  src_b_index,
    input  logic [4:0]  dest_index,
    input  logic [4:0]  shift_amount,
    input  logic [31:0] current_pc,
    input  logic [31:0] load_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reg_written,
    output logic [4:0]  written_index,
    output logic [31:0] written_value,
    output logic [31:0] hi_value,
    output logic [31:0] lo_value,
    output logic        jump_taken,
    output logic [31:0] jump_target,
    output logic        divide_by_zero
);

    mrte_pkg::state_t state_reg, state_next;

    logic [4:0]  act_reg;
    logic [4:0]  rd_reg, sh_reg;
    logic [31:0] pc_reg, ldv_reg;
    logic [31:0] hi_reg, lo_reg;
    logic [63:0] prod_reg;
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_q_reg, neg_r_reg;

    logic [31:0] a_ram, b_ram;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [31:0] wr_data;

    logic        clr_done;
    logic        accept;

    mrte_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(src_a_index), .rd_data(a_ram)
    );

    mrte_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(src_b_index), .rd_data(b_ram)
    );

    assign accept = in_valid && !in_stall;
    assign clr_done = (cnt_reg == 6'd31);
    assign in_stall = (state_reg != mrte_pkg::ST_IDLE);

    // Combinational execute for the actions that need no multiply or divide.
    logic        wr_c, jmp_c;
    logic [4:0]  widx_c;
    logic [31:0] wval_c;
    logic [4:0]  amt_c;
    logic [31:0] shr_c;

    always_comb
    begin
        amt_c = a_ram[4:0];
        if (act_reg == mrte_pkg::ACT_SRA || act_reg == mrte_pkg::ACT_SRL
            || act_reg == mrte_pkg::ACT_SLL)
        begin
            amt_c = sh_reg;
        end
        shr_c = b_ram >> amt_c;
        wr_c = 1'b1;
        jmp_c = 1'b0;
        widx_c = rd_reg;
        wval_c = '0;
        case (act_reg)
            mrte_pkg::ACT_ADD, mrte_pkg::ACT_ADDU: wval_c = a_ram + b_ram;
            mrte_pkg::ACT_SUB, mrte_pkg::ACT_SUBU: wval_c = a_ram - b_ram;
            mrte_pkg::ACT_AND:  wval_c = a_ram & b_ram;
            mrte_pkg::ACT_NOR:  wval_c = ~(a_ram | b_ram);
            mrte_pkg::ACT_OR:   wval_c = a_ram | b_ram;
            mrte_pkg::ACT_XOR:  wval_c = a_ram ^ b_ram;
            mrte_pkg::ACT_SLL, mrte_pkg::ACT_SLLV: wval_c = b_ram << amt_c;
            mrte_pkg::ACT_SRL, mrte_pkg::ACT_SRLV: wval_c = shr_c;
            mrte_pkg::ACT_SRA, mrte_pkg::ACT_SRAV:
                wval_c = $unsigned($signed(b_ram) >>> amt_c);
            mrte_pkg::ACT_SLT:
                wval_c = {31'd0, ($signed(a_ram) < $signed(b_ram))};
            mrte_pkg::ACT_SLTU: wval_c = {31'd0, (a_ram < b_ram)};
            mrte_pkg::ACT_JR:
            begin
                wr_c = 1'b0;
                jmp_c = 1'b1;
            end
            mrte_pkg::ACT_JALR:
            begin
                jmp_c = 1'b1;
                widx_c = mrte_pkg::LINK_REG;
                wval_c = pc_reg + mrte_pkg::PC_STEP;
            end
            mrte_pkg::ACT_MFHI: wval_c = hi_reg;
            mrte_pkg::ACT_MFLO: wval_c = lo_reg;
            mrte_pkg::ACT_LOAD: wval_c = ldv_reg;
            default: wr_c = 1'b0;
        endcase
        if (!wr_c)
        begin
            widx_c = '0;
            wval_c = '0;
        end
    end

    logic is_mul, is_div, signed_op;
    assign is_mul = (act_reg == mrte_pkg::ACT_MULT) || (act_reg == mrte_pkg::ACT_MULTU);
    assign is_div = (act_reg == mrte_pkg::ACT_DIV) || (act_reg == mrte_pkg::ACT_DIVU);
    assign signed_op = (act_reg == mrte_pkg::ACT_MULT) || (act_reg == mrte_pkg::ACT_DIV);

    // One 33 by 33 signed multiplier serves both mult and multu.
    logic signed [32:0] mul_a_c, mul_b_c;
    logic signed [65:0] mul_p_c;
    assign mul_a_c = {signed_op & a_ram[31], a_ram};
    assign mul_b_c = {signed_op & b_ram[31], b_ram};
    assign mul_p_c = mul_a_c * mul_b_c;

    // Restoring divider step.
    logic [32:0] trial;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrte_pkg::ST_CLEAR:  if (clr_done) state_next = mrte_pkg::ST_IDLE;
            mrte_pkg::ST_IDLE:   if (accept) state_next = mrte_pkg::ST_READ;
            mrte_pkg::ST_READ:
            begin
                if (is_mul)
                    state_next = mrte_pkg::ST_MUL;
                else if (is_div && b_ram != '0)
                    state_next = mrte_pkg::ST_DIV;
                else
                    state_next = mrte_pkg::ST_OUT;
            end
            mrte_pkg::ST_MUL:    state_next = mrte_pkg::ST_OUT;
            mrte_pkg::ST_DIV:    if (cnt_reg == 6'd31) state_next = mrte_pkg::ST_DIVFIX;
            mrte_pkg::ST_DIVFIX: state_next = mrte_pkg::ST_OUT;
            mrte_pkg::ST_OUT:    if (!out_stall) state_next = mrte_pkg::ST_IDLE;
            default:             state_next = mrte_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = widx_c;
        wr_data = wval_c;
        case (state_reg)
            mrte_pkg::ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = cnt_reg[4:0];
                wr_data = '0;
            end
            mrte_pkg::ST_READ: wr_en = wr_c;
            default: wr_en = 1'b0;
        endcase
    end

    assign out_valid = (state_reg == mrte_pkg::ST_OUT);
    assign hi_value = hi_reg;
    assign lo_value = lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrte_pkg::ST_CLEAR;
            cnt_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                mrte_pkg::ST_CLEAR: cnt_reg <= cnt_reg + 6'd1;
                mrte_pkg::ST_READ:  cnt_reg <= '0;
                mrte_pkg::ST_DIV:   cnt_reg <= cnt_reg + 6'd1;
                mrte_pkg::ST_MUL:
                begin
                    hi_reg <= prod_reg[63:32];
                    lo_reg <= prod_reg[31:0];
                end
                mrte_pkg::ST_DIVFIX:
                begin
                    lo_reg <= neg_q_reg ? (32'd0 - quo_reg) : quo_reg;
                    hi_reg <= neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            rd_reg <= dest_index;
            sh_reg <= shift_amount;
            pc_reg <= current_pc;
            ldv_reg <= load_value;
        end
        if (state_reg == mrte_pkg::ST_READ)
        begin
            reg_written <= wr_c;
            written_index <= widx_c;
            written_value <= wval_c;
            jump_taken <= jmp_c;
            jump_target <= jmp_c ? a_ram : '0;
            divide_by_zero <= is_div && (b_ram == '0);
            prod_reg <= mul_p_c[63:0];
            neg_q_reg <= signed_op && (a_ram[31] ^ b_ram[31]);
            neg_r_reg <= signed_op && a_ram[31];
            quo_reg <= (signed_op && a_ram[31]) ? (32'd0 - a_ram) : a_ram;
            dvs_reg <= (signed_op && b_ram[31]) ? (32'd0 - b_ram) : b_ram;
            rem_reg <= '0;
        end
        if (state_reg == mrte_pkg::ST_DIV)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule

/* src/mrte_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mrte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
